### design/http_header_budget_checker_macros.svh
// assertion macros for the http header budget checker
`ifndef HTTP_HEADER_BUDGET_CHECKER_MACROS_SVH
`define HTTP_HEADER_BUDGET_CHECKER_MACROS_SVH

// checked only outside reset
`define HHBC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define HHBC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### design/hhbc_pkg.sv
// shared types, codes and constants of the http header budget checker
`default_nettype none

package hhbc_pkg;

    typedef enum logic [1:0] {
        MODE_NAME  = 2'd0,
        MODE_VALUE = 2'd1,
        MODE_EOH   = 2'd2,
        MODE_EOR   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_LIMIT   = 2'd2
    } t_status;

    // register index is the doubleword address bit
    localparam logic REG_MAX_HEADER = 1'b0;
    localparam logic REG_MAX_BODY   = 1'b1;

    localparam logic [31:0] MAX_HEADER_RESET = 32'd65536;
    localparam logic [63:0] MAX_BODY_RESET   = {64{1'b1}};

    localparam logic [3:0]  NAME_LEN   = 4'd14;
    localparam logic [3:0]  NAME_SAT   = 4'd15;
    localparam logic [32:0] TOTAL_MAX  = {33{1'b1}};
    localparam logic [33:0] SEP_BYTES  = 34'd4;
    localparam logic [33:0] ONE_BYTE   = 34'd1;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5a;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef struct packed {
        logic [31:0] max_header;
        logic [63:0] max_body;
    } t_cfg;

    typedef struct packed {
        t_status     status;
        logic        present;
        logic [63:0] declared;
        logic [32:0] total;
    } t_result;

    // lower-case "content-length"
    function automatic logic [7:0] target_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

### design/hhbc_cfg.sv
// limit registers behind the apb port
`default_nettype none

module hhbc_cfg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           psel,
    input  wire logic           penable,
    input  wire logic           pwrite,
    input  wire logic [3:0]     paddr,
    input  wire logic [63:0]    pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    output hhbc_pkg::t_cfg      o_cfg
);

    logic [31:0] r_max_header;
    logic [63:0] r_max_body;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_header <= hhbc_pkg::MAX_HEADER_RESET;
            r_max_body   <= hhbc_pkg::MAX_BODY_RESET;
        end else if (w_wr) begin
            if (paddr[3] == hhbc_pkg::REG_MAX_HEADER) begin
                r_max_header <= pwdata[31:0];
            end else begin
                r_max_body <= pwdata;
            end
        end
    end

    always_comb begin
        if (paddr[3] == hhbc_pkg::REG_MAX_HEADER) begin
            prdata = {32'd0, r_max_header};
        end else begin
            prdata = r_max_body;
        end
    end

    assign o_cfg.max_header = r_max_header;
    assign o_cfg.max_body   = r_max_body;

endmodule

`default_nettype wire

### design/hhbc_core.sv
// header state, name matcher, length parser and end-of-response status
`default_nettype none

module hhbc_core (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_go,
    input  hhbc_pkg::t_mode      i_mode,
    input  wire logic [7:0]      i_byte,
    input  wire logic [63:0]     i_actual,
    input  hhbc_pkg::t_cfg       i_cfg,
    output hhbc_pkg::t_result    o_result
);

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_DIGIT = 2'd1,
        PH_TRAIL = 2'd2,
        PH_ERR   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        LERR_NONE     = 2'd0,
        LERR_INVALID  = 2'd1,
        LERR_OVERFLOW = 2'd2
    } t_len_err;

    logic [3:0]  r_name_pos,  n_name_pos;
    logic        r_name_match, n_name_match;
    t_phase      r_phase,     n_phase;
    logic [63:0] r_number,    n_number;
    logic        r_value_ovf, n_value_ovf;
    logic        r_len_seen,  n_len_seen;
    logic [63:0] r_len,       n_len;
    t_len_err    r_len_err,   n_len_err;
    logic [32:0] r_total,     n_total;

    logic [7:0]  w_low;
    logic        w_blank;
    logic        w_digit;
    logic [33:0] w_sum;
    logic [32:0] w_total_sat;
    logic [67:0] w_mul;
    logic        w_present;

    assign w_low = (i_byte >= hhbc_pkg::CH_UP_A && i_byte <= hhbc_pkg::CH_UP_Z)
                 ? i_byte + hhbc_pkg::CASE_OFS : i_byte;
    assign w_blank = (i_byte == hhbc_pkg::CH_SPACE) || (i_byte == hhbc_pkg::CH_TAB);
    assign w_digit = (i_byte >= hhbc_pkg::CH_ZERO) && (i_byte <= hhbc_pkg::CH_NINE);

    assign w_sum = {1'b0, r_total}
                 + ((i_mode == hhbc_pkg::MODE_EOH) ? hhbc_pkg::SEP_BYTES : hhbc_pkg::ONE_BYTE);
    assign w_total_sat = w_sum[33] ? hhbc_pkg::TOTAL_MAX : w_sum[32:0];

    // times ten plus digit; any carry above bit 63 means overflow
    assign w_mul = {1'b0, r_number, 3'b000} + {3'b000, r_number, 1'b0}
                 + {64'd0, i_byte[3:0]};

    always_comb begin
        n_name_pos   = r_name_pos;
        n_name_match = r_name_match;
        n_phase      = r_phase;
        n_number     = r_number;
        n_value_ovf  = r_value_ovf;
        n_len_seen   = r_len_seen;
        n_len        = r_len;
        n_len_err    = r_len_err;
        n_total      = r_total;
        case (i_mode)
            hhbc_pkg::MODE_NAME: begin
                n_total = w_total_sat;
                if (r_name_pos < hhbc_pkg::NAME_LEN) begin
                    if (w_low != hhbc_pkg::target_char(r_name_pos)) begin
                        n_name_match = 1'b0;
                    end
                    n_name_pos = r_name_pos + 4'd1;
                end else begin
                    n_name_match = 1'b0;
                    n_name_pos   = hhbc_pkg::NAME_SAT;
                end
            end
            hhbc_pkg::MODE_VALUE: begin
                n_total = w_total_sat;
                if (r_phase != PH_ERR) begin
                    if (w_blank) begin
                        if (r_phase == PH_DIGIT) begin
                            n_phase = PH_TRAIL;
                        end
                    end else if (r_phase == PH_TRAIL || !w_digit) begin
                        n_phase     = PH_ERR;
                        n_value_ovf = 1'b0;
                    end else if (w_mul[67:64] != 4'd0) begin
                        n_phase     = PH_ERR;
                        n_value_ovf = 1'b1;
                    end else begin
                        n_number = w_mul[63:0];
                        n_phase  = PH_DIGIT;
                    end
                end
            end
            hhbc_pkg::MODE_EOH: begin
                n_total = w_total_sat;
                if (r_name_match && r_name_pos == hhbc_pkg::NAME_LEN
                        && r_len_err == LERR_NONE) begin
                    if (r_len_seen || r_phase == PH_LEAD) begin
                        n_len_err = LERR_INVALID;
                    end else if (r_phase == PH_ERR) begin
                        n_len_err = r_value_ovf ? LERR_OVERFLOW : LERR_INVALID;
                    end else begin
                        n_len_seen = 1'b1;
                        n_len      = r_number;
                    end
                end
                n_name_pos   = 4'd0;
                n_name_match = 1'b1;
                n_phase      = PH_LEAD;
                n_number     = 64'd0;
                n_value_ovf  = 1'b0;
            end
            hhbc_pkg::MODE_EOR: begin
                n_name_pos   = 4'd0;
                n_name_match = 1'b1;
                n_phase      = PH_LEAD;
                n_number     = 64'd0;
                n_value_ovf  = 1'b0;
                n_len_seen   = 1'b0;
                n_len        = 64'd0;
                n_len_err    = LERR_NONE;
                n_total      = 33'd0;
            end
            default: begin
                n_total = r_total;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_pos   <= 4'd0;
            r_name_match <= 1'b1;
            r_phase      <= PH_LEAD;
            r_number     <= 64'd0;
            r_value_ovf  <= 1'b0;
            r_len_seen   <= 1'b0;
            r_len        <= 64'd0;
            r_len_err    <= LERR_NONE;
            r_total      <= 33'd0;
        end else if (i_go) begin
            r_name_pos   <= n_name_pos;
            r_name_match <= n_name_match;
            r_phase      <= n_phase;
            r_number     <= n_number;
            r_value_ovf  <= n_value_ovf;
            r_len_seen   <= n_len_seen;
            r_len        <= n_len;
            r_len_err    <= n_len_err;
            r_total      <= n_total;
        end
    end

    assign w_present = r_len_seen && (r_len_err == LERR_NONE);

    always_comb begin
        o_result.present  = w_present;
        o_result.declared = w_present ? r_len : 64'd0;
        o_result.total    = r_total;
        if (r_total > {1'b0, i_cfg.max_header}) begin
            o_result.status = hhbc_pkg::ST_LIMIT;
        end else if (r_len_err == LERR_INVALID) begin
            o_result.status = hhbc_pkg::ST_INVALID;
        end else if (r_len_err == LERR_OVERFLOW) begin
            o_result.status = hhbc_pkg::ST_LIMIT;
        end else if ((w_present && r_len > i_cfg.max_body) || i_actual > i_cfg.max_body) begin
            o_result.status = hhbc_pkg::ST_LIMIT;
        end else begin
            o_result.status = hhbc_pkg::ST_OK;
        end
    end

endmodule

`default_nettype wire

### design/http_header_budget_checker.sv
// top level: input register, header checker core, result register, apb limits
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_mode, i_data_byte, i_actual_bytes
//  result    out        o_out_valid / i_out_stall o_status, o_length_present,
//                                                  o_declared_length, o_header_total
//  config    in         psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// one transaction per cycle unless o_in_stall is high; an end of response shows its result
// from the result register; the state update sits between the input and result registers
// only an end of response waits on a stalled result register, other items never stall
// synchronous active-low reset clears the header state and loads the limit registers
`default_nettype none

module http_header_budget_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_mode,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [63:0] i_actual_bytes,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic             o_length_present,
    output logic [63:0]      o_declared_length,
    output logic [32:0]      o_header_total,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);

    logic              r_in_vld;
    hhbc_pkg::t_mode   r_mode;
    logic [7:0]        r_byte;
    logic [63:0]       r_actual;
    logic              r_out_vld;
    hhbc_pkg::t_result r_out;

    logic              w_go;
    logic              w_accept;
    logic              w_emit;
    hhbc_pkg::t_cfg    w_cfg;
    hhbc_pkg::t_result w_result;

    // an end of response may only move on if the result register is free
    assign w_go = r_in_vld && (r_mode != hhbc_pkg::MODE_EOR || !r_out_vld || !i_out_stall);
    assign w_emit     = w_go && (r_mode == hhbc_pkg::MODE_EOR);
    assign o_in_stall = r_in_vld && !w_go;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode   <= hhbc_pkg::t_mode'(i_mode);
            r_byte   <= i_data_byte;
            r_actual <= i_actual_bytes;
        end
    end

    hhbc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hhbc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_go),
        .i_mode   (r_mode),
        .i_byte   (r_byte),
        .i_actual (r_actual),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_status          = r_out.status;
    assign o_length_present  = r_out.present;
    assign o_declared_length = r_out.declared;
    assign o_header_total    = r_out.total;

`include "http_header_budget_checker_macros.svh"

    `HHBC_ASSERT(a_emit_sets_valid, w_emit |=> o_out_valid, "end of response left no result")
    `HHBC_ASSERT(a_stall_only_eor,
                 o_in_stall |-> (r_mode == hhbc_pkg::MODE_EOR && r_out_vld && i_out_stall),
                 "input stalled without a blocked end of response")
    `HHBC_ASSERT_ALWAYS(a_reset_clears, !i_rst_n |=> (!o_out_valid && !r_in_vld),
                        "reset left a transaction in flight")

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
// self-checking testbench for the http header budget checker
`timescale 1ns / 1ps

module tb_top;
    import hhbc_pkg::*;

    localparam int IDLE_PCT     = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 6;
    localparam int QUIET_LIMIT  = 5000;
    localparam int PRINT_LIMIT  = 40;
    localparam logic [63:0] ALL_ONES64 = {64{1'b1}};
    localparam logic [63:0] DECIMAL_BASE = 64'd10;

    typedef enum logic [1:0] {VP_LEAD, VP_DIGITS, VP_TRAIL, VP_BAD} value_phase_t;
    typedef enum logic [1:0] {LE_NONE, LE_INVALID, LE_OVERFLOW} length_err_t;

    typedef struct packed {
        t_mode       mode;
        logic [7:0]  data;
        logic [63:0] actual;
    } hdr_item_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    t_mode       in_mode = MODE_NAME;
    logic [7:0]  in_data = 8'd0;
    logic [63:0] in_actual = 64'd0;
    logic        out_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [63:0] pwdata = 64'd0;

    wire         o_in_stall;
    wire         o_out_valid;
    wire [1:0]   o_status;
    wire         o_length_present;
    wire [63:0]  o_declared_length;
    wire [32:0]  o_header_total;
    wire [63:0]  prdata;
    wire         pready;

    http_header_budget_checker DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (in_mode),
        .i_data_byte       (in_data),
        .i_actual_bytes    (in_actual),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (out_stall),
        .o_status          (o_status),
        .o_length_present  (o_length_present),
        .o_declared_length (o_declared_length),
        .o_header_total    (o_header_total),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #6 i_clk = ~i_clk;

    // pending stimulus and expected response summaries
    hdr_item_t pending[$];
    t_result   expected[$];
    int        pushed = 0;
    int        taken = 0;
    int        results_seen = 0;
    int        mismatches = 0;
    int        quiet = 0;
    logic      in_took = 1'b0;
    logic      hold_on = 1'b0;
    logic      calm;

    assign calm = (taken >= 500) && (taken < 800);

    string cl_name = "content-length";

    // predictor copy of the limits and the header state
    logic [31:0]  lim_header = MAX_HEADER_RESET;
    logic [63:0]  lim_body = MAX_BODY_RESET;
    logic [3:0]   name_pos = 4'd0;
    logic         name_ok = 1'b1;
    value_phase_t val_phase = VP_LEAD;
    logic [63:0]  run_num = 64'd0;
    logic         val_ovf = 1'b0;
    logic         len_seen = 1'b0;
    logic [63:0]  stored_len = 64'd0;
    length_err_t  len_err = LE_NONE;
    logic [32:0]  byte_total = 33'd0;

    task automatic add_total(input logic [33:0] n);
        logic [33:0] sum;
        sum = {1'b0, byte_total} + n;
        byte_total = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[32:0];
    endtask

    task automatic clear_header();
        name_pos = 4'd0;
        name_ok = 1'b1;
        val_phase = VP_LEAD;
        run_num = 64'd0;
        val_ovf = 1'b0;
    endtask

    task automatic absorb(input t_mode m, input logic [7:0] d, input logic [63:0] act);
        t_result    r;
        logic [7:0] low;
        logic [63:0] dig;
        logic       present;
        case (m)
            MODE_NAME: begin
                add_total(ONE_BYTE);
                low = (d >= CH_UP_A && d <= CH_UP_Z) ? d + CASE_OFS : d;
                if (name_pos < NAME_LEN) begin
                    if (low != cl_name[name_pos]) name_ok = 1'b0;
                    name_pos = name_pos + 4'd1;
                end else begin
                    name_ok = 1'b0;
                    name_pos = NAME_SAT;
                end
            end
            MODE_VALUE: begin
                add_total(ONE_BYTE);
                if (val_phase != VP_BAD) begin
                    if (d == CH_SPACE || d == CH_TAB) begin
                        if (val_phase == VP_DIGITS) val_phase = VP_TRAIL;
                    end else if (val_phase == VP_TRAIL || d < CH_ZERO || d > CH_NINE) begin
                        val_phase = VP_BAD;
                        val_ovf = 1'b0;
                    end else begin
                        dig = {56'd0, d - CH_ZERO};
                        if (run_num > (ALL_ONES64 - dig) / DECIMAL_BASE) begin
                            val_phase = VP_BAD;
                            val_ovf = 1'b1;
                        end else begin
                            run_num = run_num * DECIMAL_BASE + dig;
                            val_phase = VP_DIGITS;
                        end
                    end
                end
            end
            MODE_EOH: begin
                add_total(SEP_BYTES);
                if (name_ok && name_pos == NAME_LEN && len_err == LE_NONE) begin
                    if (len_seen || val_phase == VP_LEAD) begin
                        len_err = LE_INVALID;
                    end else if (val_phase == VP_BAD) begin
                        len_err = val_ovf ? LE_OVERFLOW : LE_INVALID;
                    end else begin
                        len_seen = 1'b1;
                        stored_len = run_num;
                    end
                end
                clear_header();
            end
            default: begin
                present = len_seen && len_err == LE_NONE;
                if (byte_total > {1'b0, lim_header})
                    r.status = ST_LIMIT;
                else if (len_err == LE_INVALID)
                    r.status = ST_INVALID;
                else if (len_err == LE_OVERFLOW)
                    r.status = ST_LIMIT;
                else if ((present && stored_len > lim_body) || act > lim_body)
                    r.status = ST_LIMIT;
                else
                    r.status = ST_OK;
                r.present = present;
                r.declared = present ? stored_len : 64'd0;
                r.total = byte_total;
                expected.push_back(r);
                clear_header();
                len_seen = 1'b0;
                stored_len = 64'd0;
                len_err = LE_NONE;
                byte_total = 33'd0;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] rand8();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] blank();
        return $urandom_range(1) ? CH_SPACE : CH_TAB;
    endfunction

    // any byte that is neither a digit nor a blank
    function automatic logic [7:0] odd_byte();
        logic [7:0] c;
        do c = rand8();
        while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_SPACE || c == CH_TAB);
        return c;
    endfunction

    function automatic string digit_text();
        string s;
        s = "";
        case ($urandom_range(5))
            0: s = $sformatf("%0d", $urandom_range(999));
            1: s = $sformatf("%0d", rand64());
            2: s = $sformatf("%0d", ALL_ONES64 - 64'($urandom_range(20)));
            3: s = $sformatf("1844674407370955161%0d", $urandom_range(4, 9));
            4: repeat ($urandom_range(1, 24)) s = {s, $sformatf("%0d", $urandom_range(9))};
            default: s = $sformatf("0%0d", $urandom_range(99));
        endcase
        return s;
    endfunction

    task automatic push_item(input t_mode m, input logic [7:0] d, input logic [63:0] a);
        hdr_item_t it;
        it.mode = m;
        it.data = d;
        it.actual = a;
        pending.push_back(it);
        pushed++;
    endtask

    task automatic push_text(input t_mode m, input string s);
        for (int i = 0; i < s.len(); i++) push_item(m, s[i], rand64());
    endtask

    task automatic push_header(input string n, input string v);
        push_text(MODE_NAME, n);
        push_text(MODE_VALUE, v);
        push_item(MODE_EOH, rand8(), rand64());
    endtask

    task automatic push_eor(input logic [63:0] a);
        push_item(MODE_EOR, rand8(), a);
    endtask

    task automatic add_text(ref logic [7:0] q[$], input string s);
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    endtask

    task automatic push_random_header();
        logic [7:0] nq[$];
        logic [7:0] vq[$];
        logic [7:0] c;
        string      num;
        logic       mixed;
        if ($urandom_range(99) < 45) begin
            for (int i = 0; i < 14; i++) begin
                c = cl_name[i];
                if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - CASE_OFS;
                nq.push_back(c);
            end
            num = digit_text();
            case ($urandom_range(9))
                6: repeat ($urandom_range(3)) vq.push_back(blank());
                7: begin
                    add_text(vq, num);
                    vq.push_back(blank());
                    add_text(vq, num);
                end
                8: begin
                    add_text(vq, num);
                    vq.insert($urandom_range(vq.size()), odd_byte());
                end
                9: add_text(vq, {"99999999999999999999", num});
                default: begin
                    repeat ($urandom_range(2)) vq.push_back(blank());
                    add_text(vq, num);
                    repeat ($urandom_range(2)) vq.push_back(blank());
                end
            endcase
        end else begin
            // near misses and arbitrary names
            case ($urandom_range(3))
                0: repeat ($urandom_range(16)) nq.push_back(rand8());
                1: add_text(nq, cl_name.substr(0, $urandom_range(12)));
                2: begin
                    add_text(nq, cl_name);
                    repeat ($urandom_range(1, 3)) nq.push_back(rand8());
                end
                default: begin
                    add_text(nq, cl_name);
                    nq[$urandom_range(13)] = rand8();
                end
            endcase
            repeat ($urandom_range(6)) vq.push_back(rand8());
        end
        mixed = $urandom_range(99) < 15;
        while (nq.size() + vq.size() != 0) begin
            if (vq.size() == 0 || (nq.size() != 0 && (!mixed || $urandom_range(1))))
                push_item(MODE_NAME, nq.pop_front(), rand64());
            else
                push_item(MODE_VALUE, vq.pop_front(), rand64());
        end
        // occasionally left open so the next bytes run on
        if ($urandom_range(99) >= 5) push_item(MODE_EOH, rand8(), rand64());
    endtask

    task automatic push_random_response();
        logic [63:0] act;
        repeat ($urandom_range(3)) push_random_header();
        if ($urandom_range(99) < 6)
            repeat ($urandom_range(1, 4)) push_item(t_mode'($urandom_range(3)), rand8(), rand64());
        case ($urandom_range(4))
            0: act = 64'd0;
            1: act = 64'($urandom_range(100000));
            2: act = rand64();
            3: act = lim_body - 64'($urandom_range(1));
            default: act = lim_body + 64'($urandom_range(1));
        endcase
        push_eor(act);
    endtask

    task automatic push_random(input int n);
        int base;
        base = pushed;
        while (pushed - base < n) push_random_response();
    endtask

    task automatic drain();
        while (taken != pushed || expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [63:0] val);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_MAX_HEADER) lim_header = val[31:0];
        else lim_body = val;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_limits(input logic [31:0] hdr, input logic [63:0] body);
        apb_write(REG_MAX_HEADER, {32'd0, hdr});
        apb_write(REG_MAX_BODY, body);
    endtask

    // accepted input transactions feed the predictor
    always @(posedge i_clk) begin
        in_took <= i_rst_n && in_valid && !o_in_stall;
        if (i_rst_n && in_valid && !o_in_stall) begin
            absorb(in_mode, in_data, in_actual);
            taken <= taken + 1;
        end
    end

    always @(negedge i_clk) begin : drive_input
        hdr_item_t it;
        if (i_rst_n && (!in_valid || in_took)) begin
            if (pending.size() != 0 && (calm || hold_on || $urandom_range(99) >= IDLE_PCT)) begin
                it = pending.pop_front();
                in_valid <= 1'b1;
                in_mode <= it.mode;
                in_data <= it.data;
                in_actual <= it.actual;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= hold_on || (!calm && $urandom_range(99) < IDLE_PCT);
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && !out_stall) begin
            results_seen <= results_seen + 1;
            if (expected.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = expected.pop_front();
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", o_status, want.status));
                if (o_length_present !== want.present)
                    report_mismatch($sformatf("length_present %b, expected %b",
                                              o_length_present, want.present));
                if (o_declared_length !== want.declared)
                    report_mismatch($sformatf("declared_length %0d, expected %0d",
                                              o_declared_length, want.declared));
                if (o_header_total !== want.total)
                    report_mismatch($sformatf("header_total %0d, expected %0d",
                                              o_header_total, want.total));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall) || psel) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("** http_header_budget_checker: FAILED **");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // hold the result side off long enough for the block to back up
    initial begin : long_hold
        while (results_seen < 20) @(negedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        hold_on <= 1'b0;
    end

    initial begin : stimulus
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_header("CoNtEnT-LeNgTh", " \t42 \t");
        push_eor(64'd0);
        push_header("content-length", " \t ");
        push_eor(rand64());
        push_header("Content-Length", "");
        push_eor(64'd0);
        push_header("content-length", "1 2");
        push_eor(64'd0);
        push_header("CONTENT-LENGTH", "18446744073709551615");
        push_eor(ALL_ONES64);
        push_header("content-length", "18446744073709551616");
        push_eor(64'd0);
        // bad character ahead of an overflowing run stays invalid
        push_header("content-length", "7x99999999999999999999999");
        push_eor(64'd0);
        push_header("content-length", "5");
        push_header("content-Length", "5");
        push_eor(64'd5);
        push_header("content-lengthx", "7");
        push_header("x-trace", "ab");
        push_eor(64'd1);
        push_text(MODE_NAME, "content-");
        push_text(MODE_VALUE, "1");
        push_text(MODE_NAME, "length");
        push_text(MODE_VALUE, "9");
        push_item(MODE_EOH, rand8(), rand64());
        push_text(MODE_NAME, "content-length");
        push_text(MODE_VALUE, "3");
        push_eor(rand64());
        push_eor(ALL_ONES64);
        drain();

        set_limits(32'd0, 64'd0);
        push_random(150);
        drain();

        set_limits({32{1'b1}}, ALL_ONES64);
        push_random(400);
        drain();

        repeat (3) begin
            case ($urandom_range(2))
                0: set_limits(32'($urandom_range(8, 120)), 64'($urandom_range(1000000)));
                1: set_limits(32'($urandom_range(8, 120)), rand64());
                default: set_limits(32'($urandom_range(8, 120)),
                                    64'd1 << $urandom_range(63));
            endcase
            push_random(250);
            drain();
        end

        if (mismatches == 0 && expected.size() == 0)
            $display("** http_header_budget_checker: PASSED **");
        else
            $display("** http_header_budget_checker: FAILED **");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/hhbc_pkg.sv
design/hhbc_cfg.sv
design/hhbc_core.sv
design/http_header_budget_checker.sv
tb/sv/tb_top.sv
